### hw/rtl/hbme_pkg.sv
// ----------------------------------------------------------------------------
// hbme_pkg
// Shared widths, register indexes and key helpers for the block matrix
// encoder.
// ----------------------------------------------------------------------------
package hbme_pkg;

  localparam int MaxDimDefault = 4;   // default block length limit
  localparam int ByteW         = 8;   // message byte and key entry width
  localparam int CipherW       = 18;  // width of one column sum
  localparam int KeyRows       = 4;   // rows (and columns) held in the key registers
  localparam int KeyRowW       = 32;  // one key row register
  localparam int KeyDimW       = 3;   // key dimension register width
  localparam int CfgIdxW       = 3;   // configuration index width
  localparam int CfgDataW      = 32;  // configuration data width

  localparam logic [KeyDimW-1:0] KeyDimReset = 3'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgKeyDim  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyRow0 = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKeyRow1 = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgKeyRow2 = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgKeyRow3 = 3'd4;

  typedef logic [KeyRows-1:0][KeyRowW-1:0] key_rows_t;

  // key entry at (row, col); anything outside the held 4x4 key reads as zero
  function automatic logic [ByteW-1:0] key_entry(input key_rows_t rows,
                                                 input int row,
                                                 input int col);
    logic [ByteW-1:0] ent;
    ent = '0;
    if (row < KeyRows && col < KeyRows) begin
      ent = rows[row][ByteW*col +: ByteW];
    end
    return ent;
  endfunction

endpackage

### hw/rtl/hill_block_matrix_encrypt.sv
// ----------------------------------------------------------------------------
// hill_block_matrix_encrypt
// Gathers message bytes into blocks and emits the block times the key matrix,
// one column sum per result transaction.
// ----------------------------------------------------------------------------
// The block takes one message byte per cycle while in_stall_o is low. After
// key_dim bytes, or at the byte flagged as the end of the message (short
// blocks are zero padded), the block is moved into a hold register and its
// key_dim column sums leave one per cycle, unless the output stalls, through
// a single column dot-product unit into the output register, block_last
// marking the last sum of a block and message_last the last sum of the
// message. Bytes keep flowing while a block drains, so with full blocks and
// no output stall the sustained rate is one byte per cycle. A byte that
// closes a block waits (in_stall_o) only while the previous block is still
// in the hold register and is not handing over its final sum in that cycle;
// output stalls can lengthen this wait. Configuration writes are taken in
// every cycle (cfg_ready_o is always high) and must only happen while idle.
// ----------------------------------------------------------------------------
module hill_block_matrix_encrypt #(
  parameter int MAX_DIM = hbme_pkg::MaxDimDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hbme_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [hbme_pkg::CfgDataW-1:0] cfg_data_i,
  // message input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [hbme_pkg::ByteW-1:0]   msg_byte_i,
  input  logic                         msg_end_i,
  // result output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [hbme_pkg::CipherW-1:0] cipher_value_o,
  output logic                         block_last_o,
  output logic                         message_last_o
);

  localparam int DimW = $clog2(MAX_DIM + 1);
  localparam int ByteW = hbme_pkg::ByteW;
  localparam int CipherW = hbme_pkg::CipherW;

  // configuration registers
  logic [hbme_pkg::KeyDimW-1:0] key_dim_q;
  hbme_pkg::key_rows_t          key_q;

  // collector
  logic [ByteW-1:0] block_q [MAX_DIM];
  logic [ByteW-1:0] block_d [MAX_DIM];
  logic [DimW-1:0]  fill_q, fill_d;

  // hold register for a closed block
  logic [ByteW-1:0] hold_q [MAX_DIM];
  logic [ByteW-1:0] hold_d [MAX_DIM];
  logic             hold_busy_q, hold_busy_d;
  logic [DimW-1:0]  hold_dim_q, hold_dim_d;
  logic             hold_last_q, hold_last_d;
  logic [DimW-1:0]  col_q, col_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [CipherW-1:0] cipher_q, cipher_d;
  logic               blast_q, blast_d;
  logic               mlast_q, mlast_d;

  logic [DimW-1:0]    dim_eff;
  logic [DimW-1:0]    fill_eff;
  logic [DimW-1:0]    fill_inc;
  logic               closes;
  logic               in_acc;
  logic               out_load;
  logic               last_col;
  logic               free_now;
  logic [CipherW-1:0] col_sum;

  assign cfg_ready_o = 1'b1;

  // configuration writes; indexes past the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_dim_q <= hbme_pkg::KeyDimReset;
      key_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hbme_pkg::CfgKeyDim:  key_dim_q <= cfg_data_i[hbme_pkg::KeyDimW-1:0];
        hbme_pkg::CfgKeyRow0: key_q[0]  <= cfg_data_i;
        hbme_pkg::CfgKeyRow1: key_q[1]  <= cfg_data_i;
        hbme_pkg::CfgKeyRow2: key_q[2]  <= cfg_data_i;
        hbme_pkg::CfgKeyRow3: key_q[3]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective dimension: zero reads as one, large values saturate
  always_comb begin
    if (key_dim_q == '0) begin
      dim_eff = DimW'(1);
    end else if (int'(key_dim_q) > MAX_DIM) begin
      dim_eff = DimW'(MAX_DIM);
    end else begin
      dim_eff = DimW'(key_dim_q);
    end
  end

  // a partial block left over from a larger dimension is dropped
  assign fill_eff = (fill_q >= dim_eff) ? '0 : fill_q;
  assign fill_inc = fill_eff + DimW'(1);
  assign closes   = (fill_inc == dim_eff) || msg_end_i;

  // output side: next column goes out when the output register frees up
  assign out_load = hold_busy_q && (!out_valid_q || !out_stall_i);
  assign last_col = (col_q == hold_dim_q - DimW'(1));
  assign free_now = out_load && last_col;

  assign in_stall_o = closes && hold_busy_q && !free_now;
  assign in_acc     = in_valid_i && !in_stall_o;

  // dot product of the held block with key column col_q
  always_comb begin
    logic [2*ByteW-1:0] prod;
    col_sum = '0;
    for (int k = 0; k < MAX_DIM; k++) begin
      prod    = hold_q[k] * hbme_pkg::key_entry(key_q, k, int'(col_q));
      col_sum = col_sum + CipherW'(prod);
    end
  end

  // collector and hold register next state
  always_comb begin
    block_d     = block_q;
    fill_d      = fill_q;
    hold_d      = hold_q;
    hold_busy_d = hold_busy_q;
    hold_dim_d  = hold_dim_q;
    hold_last_d = hold_last_q;
    col_d       = col_q;

    if (out_load) begin
      if (last_col) begin
        hold_busy_d = 1'b0;
        col_d       = '0;
      end else begin
        col_d = col_q + DimW'(1);
      end
    end

    if (in_acc) begin
      if (closes) begin
        // move the closed block over, zero padded past the new byte
        for (int k = 0; k < MAX_DIM; k++) begin
          if (DimW'(k) < fill_eff) begin
            hold_d[k] = block_q[k];
          end else if (DimW'(k) == fill_eff) begin
            hold_d[k] = msg_byte_i;
          end else begin
            hold_d[k] = '0;
          end
        end
        hold_busy_d = 1'b1;
        hold_dim_d  = dim_eff;
        hold_last_d = msg_end_i;
        col_d       = '0;
        fill_d      = '0;
      end else begin
        for (int k = 0; k < MAX_DIM; k++) begin
          if (DimW'(k) == fill_eff) begin
            block_d[k] = msg_byte_i;
          end
        end
        fill_d = fill_inc;
      end
    end
  end

  // output register next state
  always_comb begin
    out_valid_d = out_valid_q;
    cipher_d    = cipher_q;
    blast_d     = blast_q;
    mlast_d     = mlast_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      cipher_d    = col_sum;
      blast_d     = last_col;
      mlast_d     = last_col && hold_last_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      hold_busy_q <= 1'b0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      hold_busy_q <= hold_busy_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    block_q     <= block_d;
    hold_q      <= hold_d;
    hold_dim_q  <= hold_dim_d;
    hold_last_q <= hold_last_d;
    cipher_q    <= cipher_d;
    blast_q     <= blast_d;
    mlast_q     <= mlast_d;
  end

  assign out_valid_o    = out_valid_q;
  assign cipher_value_o = cipher_q;
  assign block_last_o   = blast_q;
  assign message_last_o = mlast_q;

  // column counter stays inside the held block
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_busy_q |-> (col_q < hold_dim_q))
    else $error("column counter past held block dimension");

  // input is only held back while a block occupies the hold register
  a_stall_needs_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> hold_busy_q)
    else $error("input stalled with empty hold register");

  // the final sum of a message is always the final sum of its block
  a_msg_last_on_block_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && message_last_o) |-> block_last_o)
    else $error("message_last without block_last");

  // a closed block starts draining from its first column
  a_close_starts_col0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && closes) |=> (hold_busy_q && col_q == '0))
    else $error("closed block did not start at column zero");

  // the collector never holds a full block
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(fill_q) < MAX_DIM)
    else $error("fill count reached block length");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Hill-style block matrix encoder. A directed
// table walks the key dimension limits, all-zero and all-ones keys, short
// padded blocks and a dimension drop in the middle of a block. Random phases
// with fresh keys follow. Every column sum is predicted in the bench and
// compared in order with what the block emits.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MaxDim      = hbme_pkg::MaxDimDefault;
  localparam int ByteW       = hbme_pkg::ByteW;
  localparam int CipherW     = hbme_pkg::CipherW;
  localparam int CfgIdxW     = hbme_pkg::CfgIdxW;
  localparam int CfgDataW    = hbme_pkg::CfgDataW;
  localparam int KeyDimW     = hbme_pkg::KeyDimW;
  localparam int KeyRows     = hbme_pkg::KeyRows;
  localparam int DrainCycles = 16;      // settle time before a register write
  localparam int RandItems   = 100;     // message bytes in the random part
  localparam int QuietFrom   = 75;      // no idling from here on

  // one column sum as it leaves the block
  typedef struct packed {
    logic [CipherW-1:0] value;
    logic               blk_last;
    logic               msg_last;
  } col_sum_t;

  typedef enum logic [1:0] {RowCfg, RowMsg, RowDrain} row_kind_e;

  // one line of the directed table
  typedef struct {
    row_kind_e                   kind;
    logic [CfgIdxW-1:0]          idx;
    logic [CfgDataW-1:0]         data;
    logic [ByteW-1:0]            b;
    logic                        e;
    logic                        typed_ok;
    logic [3:0][CipherW-1:0]     typed;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall_o;
  logic [ByteW-1:0]    msg_byte = '0;
  logic                msg_end = 1'b0;
  logic                out_valid_o;
  logic                out_stall = 1'b0;
  logic [CipherW-1:0]  cipher_value_o;
  logic                block_last_o;
  logic                message_last_o;

  // predictor state
  logic [KeyDimW-1:0]  key_dim_r = hbme_pkg::KeyDimReset;
  hbme_pkg::key_rows_t key_rows_r = '0;
  logic [ByteW-1:0]    blk_bytes [MaxDim];
  int                  fill = 0;

  col_sum_t            col_sum_q [$];
  stim_row_t           dir_tab [$];
  int                  err_count = 0;
  int                  bytes_sent = 0;
  int                  sums_checked = 0;
  int                  key_settings = 0;
  bit                  quiet = 1'b0;
  int                  stall_left = 0;
  int                  run_left = 0;

  hill_block_matrix_encrypt dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .msg_byte_i     (msg_byte),
    .msg_end_i      (msg_end),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .cipher_value_o (cipher_value_o),
    .block_last_o   (block_last_o),
    .message_last_o (message_last_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // output stall in random bursts, none in the quiet tail
  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (run_left > 0) begin
      out_stall <= 1'b0;
      run_left--;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 17);
      else run_left = $urandom_range(1, 40);
    end
  end

  // compare each accepted result transaction with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (col_sum_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got value %0d %s %0b %s %0b",
                 $time, cipher_value_o, "block_last", block_last_o,
                 "message_last", message_last_o);
        err_count++;
      end else begin
        col_sum_t exp_sum;
        exp_sum = col_sum_q.pop_front();
        sums_checked++;
        if (cipher_value_o !== exp_sum.value) begin
          $display("%0t: cipher_value expected %0d got %0d",
                   $time, exp_sum.value, cipher_value_o);
          err_count++;
        end
        if (block_last_o !== exp_sum.blk_last) begin
          $display("%0t: block_last expected %0b got %0b",
                   $time, exp_sum.blk_last, block_last_o);
          err_count++;
        end
        if (message_last_o !== exp_sum.msg_last) begin
          $display("%0t: message_last expected %0b got %0b",
                   $time, exp_sum.msg_last, message_last_o);
          err_count++;
        end
      end
    end
  end

  // absorb one byte into the shadow block; a closed block yields dim sums
  task automatic predict_sums(input logic [ByteW-1:0] b, input logic e,
                              input logic typed_ok, input logic [3:0][CipherW-1:0] typed);
    int       dim;
    logic [31:0] acc;
    col_sum_t s;
    dim = (key_dim_r == 0) ? 1 : ((key_dim_r > MaxDim) ? MaxDim : int'(key_dim_r));
    // a block left longer than the current dimension is dropped
    if (fill >= dim) fill = 0;
    blk_bytes[fill] = b;
    fill++;
    if (fill < dim && !e) return;
    for (int j = 0; j < dim; j++) begin
      acc = '0;
      for (int k = 0; k < fill; k++) acc += blk_bytes[k] * key_rows_r[k][ByteW*j +: ByteW];
      s.value    = typed_ok ? typed[j] : acc[CipherW-1:0];
      s.blk_last = (j == dim - 1);
      s.msg_last = e && (j == dim - 1);
      col_sum_q.push_back(s);
    end
    fill = 0;
  endtask

  // register write; valid stays up for a following write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      hbme_pkg::CfgKeyDim: begin
        key_dim_r = val[KeyDimW-1:0];
        key_settings++;
      end
      hbme_pkg::CfgKeyRow0: key_rows_r[0] = val;
      hbme_pkg::CfgKeyRow1: key_rows_r[1] = val;
      hbme_pkg::CfgKeyRow2: key_rows_r[2] = val;
      hbme_pkg::CfgKeyRow3: key_rows_r[3] = val;
      default: ;
    endcase
  endtask

  // one byte transaction, then maybe an idle burst
  task automatic send_byte(input logic [ByteW-1:0] b, input logic e,
                           input logic typed_ok, input logic [3:0][CipherW-1:0] typed);
    if (cfg_valid) cfg_valid <= 1'b0;
    in_valid <= 1'b1;
    msg_byte <= b;
    msg_end  <= e;
    do @(posedge clk_i); while (in_stall_o);
    predict_sums(b, e, typed_ok, typed);
    bytes_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // hold the sender until every predicted sum is out, then let it settle
  task automatic wait_idle();
    if (in_valid) in_valid <= 1'b0;
    if (cfg_valid) cfg_valid <= 1'b0;
    while (col_sum_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic stim_row_t cfg_row(input logic [CfgIdxW-1:0] idx,
                                        input logic [CfgDataW-1:0] data);
    stim_row_t r;
    r = '{kind: RowCfg, idx: idx, data: data, b: '0, e: 1'b0, typed_ok: 1'b0, typed: '0};
    return r;
  endfunction

  function automatic stim_row_t msg_row(input logic [ByteW-1:0] b, input logic e);
    stim_row_t r;
    r = '{kind: RowMsg, idx: '0, data: '0, b: b, e: e, typed_ok: 1'b0, typed: '0};
    return r;
  endfunction

  // byte whose sums (if any) are typed in by hand, column 0 first
  function automatic stim_row_t typed_row(input logic [ByteW-1:0] b, input logic e,
                                          input int v0, input int v1,
                                          input int v2, input int v3);
    stim_row_t r;
    r = msg_row(b, e);
    r.typed_ok = 1'b1;
    r.typed    = {CipherW'(v3), CipherW'(v2), CipherW'(v1), CipherW'(v0)};
    return r;
  endfunction

  function automatic stim_row_t drain_row();
    stim_row_t r;
    r = '{kind: RowDrain, idx: '0, data: '0, b: '0, e: 1'b0, typed_ok: 1'b0, typed: '0};
    return r;
  endfunction

  // time limit
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // main sequence
  initial begin
    int rand_bytes;
    int phase;
    int n_msg;
    int len;
    int dir_bytes;
    logic [KeyDimW-1:0] new_dim;

    for (int k = 0; k < MaxDim; k++) blk_bytes[k] = '0;

    // reset defaults: dim 2, zero key
    dir_tab.push_back(typed_row(8'hFF, 1'b0, 0, 0, 0, 0));
    dir_tab.push_back(typed_row(8'h00, 1'b1, 0, 0, 0, 0));
    dir_tab.push_back(drain_row());
    // all-ones key at full dimension: largest sums, then an all-zero block
    dir_tab.push_back(cfg_row(hbme_pkg::CfgKeyRow0, '1));
    dir_tab.push_back(cfg_row(hbme_pkg::CfgKeyRow1, '1));
    dir_tab.push_back(cfg_row(hbme_pkg::CfgKeyRow2, '1));
    dir_tab.push_back(cfg_row(hbme_pkg::CfgKeyRow3, '1));
    dir_tab.push_back(cfg_row(hbme_pkg::CfgKeyDim, 32'd4));
    dir_tab.push_back(typed_row(8'hFF, 1'b0, 0, 0, 0, 0));
    dir_tab.push_back(typed_row(8'hFF, 1'b0, 0, 0, 0, 0));
    dir_tab.push_back(typed_row(8'hFF, 1'b0, 0, 0, 0, 0));
    dir_tab.push_back(typed_row(8'hFF, 1'b1, 260100, 260100, 260100, 260100));
    dir_tab.push_back(typed_row(8'h00, 1'b0, 0, 0, 0, 0));
    dir_tab.push_back(typed_row(8'h00, 1'b0, 0, 0, 0, 0));
    dir_tab.push_back(typed_row(8'h00, 1'b0, 0, 0, 0, 0));
    dir_tab.push_back(typed_row(8'h00, 1'b0, 0, 0, 0, 0));
    dir_tab.push_back(drain_row());
    // dimension zero acts as one
    dir_tab.push_back(cfg_row(hbme_pkg::CfgKeyDim, 32'd0));
    dir_tab.push_back(typed_row(8'h80, 1'b0, 32640, 0, 0, 0));
    dir_tab.push_back(typed_row(8'h01, 1'b1, 255, 0, 0, 0));
    dir_tab.push_back(drain_row());
    // dimension seven saturates to four; short blocks are zero padded
    dir_tab.push_back(cfg_row(hbme_pkg::CfgKeyRow0, 32'h0403_0201));
    dir_tab.push_back(cfg_row(hbme_pkg::CfgKeyRow1, 32'h0807_0605));
    dir_tab.push_back(cfg_row(hbme_pkg::CfgKeyRow2, 32'h0C0B_0A09));
    dir_tab.push_back(cfg_row(hbme_pkg::CfgKeyRow3, 32'h100F_0E0D));
    dir_tab.push_back(cfg_row(hbme_pkg::CfgKeyDim, 32'd7));
    dir_tab.push_back(typed_row(8'h01, 1'b1, 1, 2, 3, 4));
    dir_tab.push_back(typed_row(8'h02, 1'b0, 0, 0, 0, 0));
    dir_tab.push_back(typed_row(8'h01, 1'b1, 7, 10, 13, 16));
    dir_tab.push_back(drain_row());
    // odd dimension: one full block, one short one
    dir_tab.push_back(cfg_row(hbme_pkg::CfgKeyDim, 32'd3));
    dir_tab.push_back(msg_row(8'hAA, 1'b0));
    dir_tab.push_back(msg_row(8'h55, 1'b0));
    dir_tab.push_back(msg_row(8'h3C, 1'b0));
    dir_tab.push_back(msg_row(8'hC3, 1'b1));
    dir_tab.push_back(drain_row());
    // partial block of three, then the dimension drops to two: block dropped
    dir_tab.push_back(cfg_row(hbme_pkg::CfgKeyDim, 32'd4));
    dir_tab.push_back(msg_row(8'h11, 1'b0));
    dir_tab.push_back(msg_row(8'h22, 1'b0));
    dir_tab.push_back(msg_row(8'h33, 1'b0));
    dir_tab.push_back(drain_row());
    dir_tab.push_back(cfg_row(hbme_pkg::CfgKeyDim, 32'd2));
    dir_tab.push_back(typed_row(8'h05, 1'b0, 0, 0, 0, 0));
    dir_tab.push_back(typed_row(8'h07, 1'b1, 40, 52, 0, 0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_tab[i]) begin
      case (dir_tab[i].kind)
        RowCfg:   write_reg(dir_tab[i].idx, dir_tab[i].data);
        RowMsg:   send_byte(dir_tab[i].b, dir_tab[i].e, dir_tab[i].typed_ok, dir_tab[i].typed);
        RowDrain: wait_idle();
        default: ;
      endcase
    end
    dir_bytes = bytes_sent;

    // random phases: new key each time, whole messages plus the odd cut-off block
    rand_bytes = 0;
    phase = 0;
    while (rand_bytes < RandItems) begin
      wait_idle();
      if (rand_bytes >= QuietFrom) quiet = 1'b1;
      case (phase)
        0: new_dim = KeyDimW'(1);
        1: new_dim = KeyDimW'(4);
        default: new_dim = KeyDimW'($urandom_range(0, 7));
      endcase
      write_reg(hbme_pkg::CfgKeyDim, CfgDataW'(new_dim));
      for (int r = 0; r < KeyRows; r++) begin
        case ($urandom_range(0, 4))
          0: write_reg(CfgIdxW'(hbme_pkg::CfgKeyRow0 + r), '1);
          1: write_reg(CfgIdxW'(hbme_pkg::CfgKeyRow0 + r), '0);
          default: write_reg(CfgIdxW'(hbme_pkg::CfgKeyRow0 + r), $urandom);
        endcase
      end
      n_msg = $urandom_range(1, 3);
      for (int m = 0; m < n_msg; m++) begin
        len = $urandom_range(1, 9);
        for (int k = 0; k < len; k++) begin
          send_byte(pick_byte(), k == len - 1, 1'b0, '0);
          rand_bytes++;
        end
      end
      // message cut off without its end byte
      if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) begin
          send_byte(pick_byte(), 1'b0, 1'b0, '0);
          rand_bytes++;
        end
      end
      phase++;
    end

    if (in_valid) in_valid <= 1'b0;
    while (col_sum_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d message bytes (%0d from the directed table) in %0d random phases,",
             bytes_sent, dir_bytes, phase);
    $display("%0d key dimension settings, %0d column sums checked, %0d mismatches.",
             key_settings, sums_checked, err_count);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
